### hw/rtl/rsi_pkg.sv
// Package for the ray-sphere intersection block: widths, constants and payload types.
`timescale 1ns / 1ps

package rsi_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;

    // ec = origin - center
    localparam int EW   = COORD_BITS + 1;
    // half width of the magnitudes that feed the split squarings
    localparam int HW   = COORD_BITS + 1;
    // b = d.ec, also E = ee - rr (signed)
    localparam int BW   = 2 * HW + 1;
    // dd = d.d (unsigned)
    localparam int DDW  = 2 * COORD_BITS;
    // ee = ec.ec (unsigned)
    localparam int EEW  = 2 * COORD_BITS + 2;
    // root width and discriminant width
    localparam int SQS  = BW;
    localparam int DW   = 2 * SQS;
    // scaled numerator magnitude
    localparam int NMW  = BW + FRAC_BITS;

    localparam logic [COORD_BITS-1:0] NEG_ONE =
        {{(COORD_BITS-FRAC_BITS){1'b1}}, {FRAC_BITS{1'b0}}};
    localparam logic [COORD_BITS-1:0] SAT_POS = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic [COORD_BITS-1:0] SAT_NEG = {1'b1, {(COORD_BITS-1){1'b0}}};

    typedef struct packed {
        logic signed [COORD_BITS-1:0] ray_origin_x;
        logic signed [COORD_BITS-1:0] ray_origin_y;
        logic signed [COORD_BITS-1:0] ray_origin_z;
        logic signed [COORD_BITS-1:0] ray_dir_x;
        logic signed [COORD_BITS-1:0] ray_dir_y;
        logic signed [COORD_BITS-1:0] ray_dir_z;
        logic signed [COORD_BITS-1:0] center_x;
        logic signed [COORD_BITS-1:0] center_y;
        logic signed [COORD_BITS-1:0] center_z;
        logic        [COORD_BITS-2:0] sphere_radius;
    } rsi_in_t;

    typedef struct packed {
        logic                         hit;
        logic signed [COORD_BITS-1:0] hit_param;
    } rsi_out_t;

    // sideband that rides along the root and divide pipelines
    typedef struct packed {
        logic                 nohit;
        logic signed [BW-1:0] b;
        logic        [DDW-1:0] dd;
    } rsi_side_t;

endpackage

### hw/rtl/rsi_isqrt.sv
// Pipelined floor square root of the discriminant, one root bit per stage.
`timescale 1ns / 1ps

module rsi_isqrt import rsi_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            advance,
    input  logic            in_valid,
    input  logic [DW-1:0]   in_rad,
    input  rsi_side_t       in_side,
    output logic            out_valid,
    output logic [SQS-1:0]  out_root,
    output rsi_side_t       out_side
);

    logic [SQS+1:0] rem_reg   [SQS];
    logic [SQS-1:0] root_reg  [SQS];
    logic [DW-1:0]  rad_reg   [SQS];
    rsi_side_t      side_reg  [SQS];
    logic [SQS-1:0] vld_reg;

    logic [SQS+1:0] src_rem   [SQS];
    logic [SQS-1:0] src_root  [SQS];
    logic [DW-1:0]  src_rad   [SQS];
    logic [SQS+1:0] rem_try   [SQS];
    logic [SQS+1:0] trial     [SQS];
    logic [SQS+1:0] rem_next  [SQS];
    logic [SQS-1:0] root_next [SQS];
    logic [DW-1:0]  rad_next  [SQS];

    always_comb begin
        for (int k = 0; k < SQS; k++) begin
            if (k == 0) begin
                src_rem[k]  = '0;
                src_root[k] = '0;
                src_rad[k]  = in_rad;
            end else begin
                src_rem[k]  = rem_reg[k-1];
                src_root[k] = root_reg[k-1];
                src_rad[k]  = rad_reg[k-1];
            end
            rem_try[k] = {src_rem[k][SQS-1:0], src_rad[k][DW-1 -: 2]};
            trial[k]   = {src_root[k], 2'b01};
            if (rem_try[k] >= trial[k]) begin
                rem_next[k]  = rem_try[k] - trial[k];
                root_next[k] = {src_root[k][SQS-2:0], 1'b1};
            end else begin
                rem_next[k]  = rem_try[k];
                root_next[k] = {src_root[k][SQS-2:0], 1'b0};
            end
            rad_next[k] = {src_rad[k][DW-3:0], 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (advance) begin
            vld_reg <= {vld_reg[SQS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int k = 0; k < SQS; k++) begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                rad_reg[k]  <= rad_next[k];
                side_reg[k] <= (k == 0) ? in_side : side_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[SQS-1];
    assign out_root  = root_reg[SQS-1];
    assign out_side  = side_reg[SQS-1];

endmodule

### hw/rtl/rsi_divide.sv
// Pipelined floor division of the scaled near root by d.d, with saturation.
`timescale 1ns / 1ps

module rsi_divide import rsi_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            advance,
    input  logic            in_valid,
    input  logic [SQS-1:0]  in_root,
    input  rsi_side_t       in_side,
    output logic            out_valid,
    output rsi_out_t        out_data
);

    // numerator prep stage
    logic [BW:0]     bx;
    logic [BW:0]     sx;
    logic [BW:0]     x_val;
    logic [BW:0]     x_neg;
    logic [BW-1:0]   mag;
    logic [NMW-1:0]  pr_num_reg;
    logic            pr_neg_reg;
    logic            pr_nohit_reg;
    logic [DDW-1:0]  pr_dd_reg;
    logic            pr_vld_reg;

    // restoring divide stages
    logic [DDW:0]    rem_reg   [NMW];
    logic [NMW-1:0]  quo_reg   [NMW];
    logic [NMW-1:0]  num_reg   [NMW];
    logic [DDW-1:0]  dd_reg    [NMW];
    logic            neg_reg   [NMW];
    logic            nohit_reg [NMW];
    logic [NMW-1:0]  dv_vld_reg;

    logic [DDW:0]    src_rem   [NMW];
    logic [NMW-1:0]  src_quo   [NMW];
    logic [NMW-1:0]  src_num   [NMW];
    logic [DDW-1:0]  src_dd    [NMW];
    logic [DDW:0]    rem_try   [NMW];
    logic [DDW:0]    rem_next  [NMW];
    logic [NMW-1:0]  quo_next  [NMW];

    // final stage
    logic            rem_nz;
    logic [NMW:0]    quo_adj;
    rsi_out_t        out_next;
    rsi_out_t        out_data_reg;
    logic            out_vld_reg;

    always_comb begin
        bx    = {in_side.b[BW-1], in_side.b};
        sx    = {1'b0, in_root};
        x_val = (BW+1)'(0) - bx - sx;
        x_neg = (BW+1)'(0) - x_val;
        mag   = x_val[BW] ? x_neg[BW-1:0] : x_val[BW-1:0];
    end

    always_comb begin
        for (int k = 0; k < NMW; k++) begin
            if (k == 0) begin
                src_rem[k] = '0;
                src_quo[k] = '0;
                src_num[k] = pr_num_reg;
                src_dd[k]  = pr_dd_reg;
            end else begin
                src_rem[k] = rem_reg[k-1];
                src_quo[k] = quo_reg[k-1];
                src_num[k] = num_reg[k-1];
                src_dd[k]  = dd_reg[k-1];
            end
            rem_try[k] = {src_rem[k][DDW-1:0], src_num[k][NMW-1]};
            if (rem_try[k] >= {1'b0, src_dd[k]}) begin
                rem_next[k] = rem_try[k] - {1'b0, src_dd[k]};
                quo_next[k] = {src_quo[k][NMW-2:0], 1'b1};
            end else begin
                rem_next[k] = rem_try[k];
                quo_next[k] = {src_quo[k][NMW-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        rem_nz  = |rem_reg[NMW-1];
        quo_adj = (NMW+1)'(quo_reg[NMW-1]) + (NMW+1)'(neg_reg[NMW-1] & rem_nz);
        out_next.hit = 1'b1;
        if (nohit_reg[NMW-1]) begin
            out_next.hit       = 1'b0;
            out_next.hit_param = NEG_ONE;
        end else if (neg_reg[NMW-1]) begin
            if (quo_adj >= (NMW+1)'(SAT_NEG)) begin
                out_next.hit_param = SAT_NEG;
            end else begin
                out_next.hit_param = COORD_BITS'(0) - quo_adj[COORD_BITS-1:0];
            end
        end else begin
            if (quo_reg[NMW-1] >= NMW'(SAT_POS)) begin
                out_next.hit_param = SAT_POS;
            end else begin
                out_next.hit_param = quo_reg[NMW-1][COORD_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pr_vld_reg  <= 1'b0;
            dv_vld_reg  <= '0;
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            pr_vld_reg  <= in_valid;
            dv_vld_reg  <= {dv_vld_reg[NMW-2:0], pr_vld_reg};
            out_vld_reg <= dv_vld_reg[NMW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            pr_num_reg   <= {mag, {FRAC_BITS{1'b0}}};
            pr_neg_reg   <= x_val[BW];
            pr_nohit_reg <= in_side.nohit;
            pr_dd_reg    <= in_side.dd;
            for (int k = 0; k < NMW; k++) begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
                num_reg[k] <= {src_num[k][NMW-2:0], 1'b0};
                dd_reg[k]  <= src_dd[k];
                neg_reg[k]   <= (k == 0) ? pr_neg_reg   : neg_reg[k-1];
                nohit_reg[k] <= (k == 0) ? pr_nohit_reg : nohit_reg[k-1];
            end
            out_data_reg <= out_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

endmodule

### hw/rtl/ray_sphere_intersection.sv
// Top level of the ray-sphere intersection block: front stages, root, divide, output skid.
// Pipeline: 159 register stages (6 front, 67 root, 85 divide, one output register),
//   with one root bit and one quotient bit per stage.
// Throughput: one word per cycle; the whole pipeline advances together while the skid is empty.
// Reset: aresetn (synchronous, active low) clears all valid bits; payload is not reset.
`timescale 1ns / 1ps

module ray_sphere_intersection import rsi_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  rsi_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output rsi_out_t m_data
);

    // Advance every stage together; only a full skid register holds the pipeline.
    logic adv;
    logic [5:0] v_reg;

    // stage 1: ec = origin - center, keep direction and radius
    logic signed [EW-1:0]         ec_next  [3];
    logic signed [COORD_BITS-1:0] dv_next  [3];
    logic signed [EW-1:0]         ec_reg   [3];
    logic signed [COORD_BITS-1:0] dv_reg   [3];
    logic [COORD_BITS-2:0]        rad_reg;

    // stage 2: the ten component products
    logic signed [2*COORD_BITS:0]   pb_next [3];
    logic [DDW-1:0]                 pd_next [3];
    logic [2*COORD_BITS:0]          pe_next [3];
    logic signed [2*COORD_BITS:0]   pb_reg  [3];
    logic [DDW-1:0]                 pd_reg  [3];
    logic [2*COORD_BITS:0]          pe_reg  [3];
    logic [2*COORD_BITS-3:0]        pr_reg;

    // stage 3: dot sums, E = ee - rr, magnitudes for the wide squarings
    logic signed [BW-1:0] b_sum;
    logic [BW-1:0]        b_neg;
    logic [DDW-1:0]       dd_sum;
    logic [EEW-1:0]       ee_sum;
    logic [BW-1:0]        e_val;
    logic [BW-1:0]        e_neg;
    logic signed [BW-1:0] s3_b_reg;
    logic [DDW-1:0]       s3_dd_reg;
    logic [2*HW-1:0]      s3_babs_reg;
    logic [2*HW-1:0]      s3_eabs_reg;
    logic                 s3_eneg_reg;

    // stage 4: half-width partial products of b*b and dd*|E|
    logic [2*HW-1:0]      dde;
    logic [2*HW-1:0]      bhh_reg, bhl_reg, bll_reg;
    logic [2*HW-1:0]      ehh_reg, ehl_reg, elh_reg, ell_reg;
    logic signed [BW-1:0] s4_b_reg;
    logic [DDW-1:0]       s4_dd_reg;
    logic                 s4_ddz_reg;
    logic                 s4_eneg_reg;

    // stage 5: assemble the two squares
    logic [4*HW-1:0]      bb_reg, pe_sum_reg;
    logic signed [BW-1:0] s5_b_reg;
    logic [DDW-1:0]       s5_dd_reg;
    logic                 s5_ddz_reg;
    logic                 s5_eneg_reg;

    // stage 6: discriminant and the no-hit flag
    logic [DW-1:0]        disc_next;
    logic [DW-1:0]        disc_reg;
    rsi_side_t            side_next;
    rsi_side_t            side_reg;

    // root and divide pipelines
    logic                 sq_valid;
    logic [SQS-1:0]       sq_root;
    rsi_side_t            sq_side;
    logic                 p_valid;
    rsi_out_t             p_data;

    // output register and skid
    logic     m_take;
    logic     m_valid_reg, m_valid_next;
    logic     skid_valid_reg, skid_valid_next;
    rsi_out_t m_data_reg, m_data_next;
    rsi_out_t skid_data_reg, skid_data_next;

    assign adv     = !skid_valid_reg;
    assign s_ready = adv;

    always_comb begin
        ec_next[0] = s_data.ray_origin_x - s_data.center_x;
        ec_next[1] = s_data.ray_origin_y - s_data.center_y;
        ec_next[2] = s_data.ray_origin_z - s_data.center_z;
        dv_next[0] = s_data.ray_dir_x;
        dv_next[1] = s_data.ray_dir_y;
        dv_next[2] = s_data.ray_dir_z;
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pb_next[i] = dv_reg[i] * ec_reg[i];
            pd_next[i] = dv_reg[i] * dv_reg[i];
            pe_next[i] = ec_reg[i] * ec_reg[i];
        end
    end

    always_comb begin
        b_sum  = pb_reg[0] + pb_reg[1] + pb_reg[2];
        b_neg  = BW'(0) - b_sum;
        dd_sum = pd_reg[0] + pd_reg[1] + pd_reg[2];
        ee_sum = EEW'(pe_reg[0]) + EEW'(pe_reg[1]) + EEW'(pe_reg[2]);
        e_val  = BW'(ee_sum) - BW'(pr_reg);
        e_neg  = BW'(0) - e_val;
    end

    assign dde = (2*HW)'(s3_dd_reg);

    always_comb begin
        disc_next = s5_eneg_reg ? (DW'(bb_reg) + DW'(pe_sum_reg))
                                : (DW'(bb_reg) - DW'(pe_sum_reg));
        side_next.nohit = s5_ddz_reg | disc_next[DW-1];
        side_next.b     = s5_b_reg;
        side_next.dd    = s5_dd_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[4:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                ec_reg[i] <= ec_next[i];
                dv_reg[i] <= dv_next[i];
                pb_reg[i] <= pb_next[i];
                pd_reg[i] <= pd_next[i];
                pe_reg[i] <= pe_next[i];
            end
            rad_reg <= s_data.sphere_radius;
            pr_reg  <= rad_reg * rad_reg;

            s3_b_reg    <= b_sum;
            s3_dd_reg   <= dd_sum;
            s3_babs_reg <= b_sum[BW-1] ? b_neg[2*HW-1:0] : b_sum[2*HW-1:0];
            s3_eabs_reg <= e_val[BW-1] ? e_neg[2*HW-1:0] : e_val[2*HW-1:0];
            s3_eneg_reg <= e_val[BW-1];

            bhh_reg     <= s3_babs_reg[2*HW-1:HW] * s3_babs_reg[2*HW-1:HW];
            bhl_reg     <= s3_babs_reg[2*HW-1:HW] * s3_babs_reg[HW-1:0];
            bll_reg     <= s3_babs_reg[HW-1:0] * s3_babs_reg[HW-1:0];
            ehh_reg     <= dde[2*HW-1:HW] * s3_eabs_reg[2*HW-1:HW];
            ehl_reg     <= dde[2*HW-1:HW] * s3_eabs_reg[HW-1:0];
            elh_reg     <= dde[HW-1:0] * s3_eabs_reg[2*HW-1:HW];
            ell_reg     <= dde[HW-1:0] * s3_eabs_reg[HW-1:0];
            s4_b_reg    <= s3_b_reg;
            s4_dd_reg   <= s3_dd_reg;
            s4_ddz_reg  <= (s3_dd_reg == '0);
            s4_eneg_reg <= s3_eneg_reg;

            // cross term of the square appears twice: shift it one more place
            bb_reg      <= ((4*HW)'(bhh_reg) << (2*HW)) + ((4*HW)'(bhl_reg) << (HW+1))
                         + (4*HW)'(bll_reg);
            pe_sum_reg  <= ((4*HW)'(ehh_reg) << (2*HW))
                         + (((4*HW)'(ehl_reg) + (4*HW)'(elh_reg)) << HW)
                         + (4*HW)'(ell_reg);
            s5_b_reg    <= s4_b_reg;
            s5_dd_reg   <= s4_dd_reg;
            s5_ddz_reg  <= s4_ddz_reg;
            s5_eneg_reg <= s4_eneg_reg;

            disc_reg    <= disc_next;
            side_reg    <= side_next;
        end
    end

    rsi_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (adv),
        .in_valid  (v_reg[5]),
        .in_rad    (disc_reg),
        .in_side   (side_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    rsi_divide u_divide (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (adv),
        .in_valid  (sq_valid),
        .in_root   (sq_root),
        .in_side   (sq_side),
        .out_valid (p_valid),
        .out_data  (p_data)
    );

    // Output register with one skid word: a finished word lands in the skid only
    // when the output register is full and not being taken.
    always_comb begin
        m_take          = m_valid_reg && m_ready;
        m_valid_next    = m_valid_reg;
        skid_valid_next = skid_valid_reg;
        m_data_next     = m_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (m_take) begin
                m_data_next     = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (p_valid) begin
            if (!m_valid_reg || m_take) begin
                m_data_next  = p_data;
                m_valid_next = 1'b1;
            end else begin
                skid_data_next  = p_data;
                skid_valid_next = 1'b1;
            end
        end else if (m_take) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg    <= m_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // skid holds a word only behind a full output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid word without output word");

    // a finished word meeting a stalled output must land in the skid
    assert property (@(posedge aclk) disable iff (!aresetn)
        p_valid && !skid_valid_reg && m_valid_reg && !m_ready |=> skid_valid_reg)
        else $error("finished word dropped at stalled output");

    // a held pipeline keeps its last word
    assert property (@(posedge aclk) disable iff (!aresetn)
        !adv && p_valid |=> p_valid)
        else $error("pipeline word lost while held");

endmodule

### tb/sv/rsi_checker.sv
// Checker for the ray-sphere block: watches both channels, predicts each result and compares.
`timescale 1ns / 1ps

module rsi_checker import rsi_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  rsi_in_t  s_data,
    input  logic     m_valid,
    input  logic     m_ready,
    input  rsi_out_t m_data,
    output int       fail_count,
    output int       pending_count,
    output int       hit_count,
    output int       miss_count
);

    rsi_out_t intersect_q[$];

    // Floor square root of a non-negative 256-bit value.
    function automatic logic [255:0] floor_root(input logic [255:0] v);
        logic [255:0] r;
        logic [255:0] c;
        r = '0;
        for (int i = 127; i >= 0; i--) begin
            c = r | (256'd1 << i);
            if (c * c <= v) r = c;
        end
        return r;
    endfunction

    // Compute the nearer intersection, exact in 256-bit arithmetic.
    function automatic rsi_out_t predict_hit(input rsi_in_t w);
        logic signed [255:0] dx, dy, dz, ex, ey, ez, rad;
        logic signed [255:0] b, dd, ee, disc, num, mag, q, hp, hn;
        logic [255:0] s;
        logic rem_nz, neg;
        rsi_out_t o;
        dx  = 256'(w.ray_dir_x);
        dy  = 256'(w.ray_dir_y);
        dz  = 256'(w.ray_dir_z);
        ex  = 256'(w.ray_origin_x) - 256'(w.center_x);
        ey  = 256'(w.ray_origin_y) - 256'(w.center_y);
        ez  = 256'(w.ray_origin_z) - 256'(w.center_z);
        rad = $signed({225'd0, w.sphere_radius});
        b   = dx * ex + dy * ey + dz * ez;
        dd  = dx * dx + dy * dy + dz * dz;
        ee  = ex * ex + ey * ey + ez * ez;
        disc = b * b - dd * (ee - rad * rad);
        if (dd == 0 || disc < 0) begin
            o.hit = 1'b0;
            o.hit_param = NEG_ONE;
            return o;
        end
        s   = floor_root(disc);
        num = (-b - $signed(s)) <<< FRAC_BITS;
        neg = num < 0;
        mag = neg ? -num : num;
        q   = mag / dd;
        rem_nz = (mag % dd) != 0;
        if (neg && rem_nz) q = q + 1;
        hp = 256'(SAT_POS);
        hn = 256'(1) <<< (COORD_BITS - 1);
        o.hit = 1'b1;
        if (neg) o.hit_param = (q >= hn) ? SAT_NEG : COORD_BITS'(-q);
        else     o.hit_param = (q >= hp) ? SAT_POS : COORD_BITS'(q);
        return o;
    endfunction

    assign pending_count = intersect_q.size();

    initial begin
        fail_count = 0;
        hit_count  = 0;
        miss_count = 0;
    end

    always @(posedge aclk) begin
        rsi_out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) intersect_q.push_back(predict_hit(s_data));
            if (m_valid && m_ready) begin
                if (intersect_q.size() == 0) begin
                    $display("%0t: unexpected word hit=%0b t=%h", $time, m_data.hit,
                             m_data.hit_param);
                    fail_count++;
                end else begin
                    want = intersect_q.pop_front();
                    if (m_data.hit) hit_count++; else miss_count++;
                    if (m_data.hit !== want.hit) begin
                        $display("%0t: hit expected %0b actual %0b", $time, want.hit,
                                 m_data.hit);
                        fail_count++;
                    end
                    if (m_data.hit_param !== want.hit_param) begin
                        $display("%0t: hit_param expected %h actual %h", $time,
                                 want.hit_param, m_data.hit_param);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

### tb/sv/testbench.sv
// Testbench top for the ray-sphere block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
    import rsi_pkg::*;

    localparam int LATENCY     = 160;
    localparam int RANDOM_RAYS = 1300;
    localparam int STALL_LIMIT = 5000;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    rsi_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    rsi_out_t m_data;
    int       fail_count, pending_count, hit_count, miss_count;
    int       quiet_cycles = 0;
    int       sent = 0;
    bit       calm = 1'b0;   // set in the last part of the run: no idling

    always #4 aclk = ~aclk;

    ray_sphere_intersection dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    rsi_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending_count(pending_count),
        .hit_count(hit_count), .miss_count(miss_count)
    );

    // Watchdog: count cycles with no accepted word on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: stall in random bursts, stay ready during the calm tail.
    initial begin
        int n;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!calm && $urandom_range(0, 15) == 0) begin
                n = $urandom_range(1, 19);
                m_ready <= 1'b0;
                repeat (n) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            default: return 32'($signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000);
        endcase
    endfunction

    // Build a ray aimed roughly at the sphere so most items hit.
    function automatic rsi_in_t aimed_ray();
        rsi_in_t w;
        w.center_x = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        w.center_y = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        w.center_z = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        w.ray_origin_x = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        w.ray_origin_y = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        w.ray_origin_z = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        w.ray_dir_x = w.center_x - w.ray_origin_x + $signed($urandom_range(0, 32'h4_0000))
                      - 32'sh2_0000;
        w.ray_dir_y = w.center_y - w.ray_origin_y + $signed($urandom_range(0, 32'h4_0000))
                      - 32'sh2_0000;
        w.ray_dir_z = w.center_z - w.ray_origin_z + $signed($urandom_range(0, 32'h4_0000))
                      - 32'sh2_0000;
        w.sphere_radius = 31'($urandom_range(0, 32'h0030_0000));
        return w;
    endfunction

    function automatic rsi_in_t noise_ray();
        rsi_in_t w;
        w.ray_origin_x = rand_coord(); w.ray_origin_y = rand_coord();
        w.ray_origin_z = rand_coord();
        w.ray_dir_x = rand_coord(); w.ray_dir_y = rand_coord(); w.ray_dir_z = rand_coord();
        w.center_x = rand_coord(); w.center_y = rand_coord(); w.center_z = rand_coord();
        w.sphere_radius = ($urandom_range(0, 3) == 0) ? 31'h7fff_ffff : 31'($urandom());
        return w;
    endfunction

    // Offer one word, hold it until accepted, then maybe idle a burst.
    task automatic send_ray(input rsi_in_t w);
        s_data  <= w;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
        @(negedge aclk);
        if (!calm && $urandom_range(0, 15) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
    endtask

    function automatic rsi_in_t ray_of(input logic [31:0] ox, oy, oz, dx, dy, dz,
                                       cx, cy, cz, input logic [30:0] r);
        rsi_in_t w;
        w = '{ox, oy, oz, dx, dy, dz, cx, cy, cz, r};
        return w;
    endfunction

    initial begin
        int waited;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: hit in front, ray starting inside, sphere behind (negative root),
        // clear miss, zero direction, tangent, and all-extreme fields.
        send_ray(ray_of(0, 0, 0, 32'h1_0000, 0, 0, 32'ha_0000, 0, 0, 31'h1_0000));
        send_ray(ray_of(0, 0, 0, 0, 32'h1_0000, 0, 0, 0, 0, 31'h2_0000));
        send_ray(ray_of(0, 0, 0, 32'hffff_0000, 0, 0, 32'h5_0000, 0, 0, 31'h1_0000));
        send_ray(ray_of(0, 0, 0, 32'h1_0000, 0, 0, 0, 32'h5_0000, 0, 31'h1_0000));
        send_ray(ray_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 31'h1_0000));
        send_ray(ray_of(0, 0, 0, 0, 0, 0, 32'h7fff_ffff, 0, 0, 31'h7fff_ffff));
        send_ray(ray_of(0, 32'h1_0000, 0, 32'h1_0000, 0, 0, 32'h5_0000, 0, 0, 31'h1_0000));
        send_ray(ray_of(0, 0, 0, 32'h0000_0001, 0, 0, 32'h7fff_0000, 0, 0, 31'h1_0000));
        send_ray(ray_of(0, 0, 0, 32'h0000_0001, 0, 0, 32'h8000_0000, 0, 0, 31'h1_0000));
        send_ray(ray_of(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 31'h7fff_ffff));
        send_ray(ray_of(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                        32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                        32'h7fff_ffff, 31'h7fff_ffff));
        send_ray(ray_of(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                        32'hffff_ffff, 32'hffff_ffff, 0, 0, 0, 31'h7fff_ffff));
        send_ray(ray_of(0, 0, 0, 32'h8000_0000, 0, 0, 0, 0, 0, 0));
        send_ray(ray_of(0, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0,
                        31'h7fff_ffff));

        // Random: mostly aimed rays with random content, some full-range noise.
        for (int i = 0; i < RANDOM_RAYS; i++) begin
            if (i > RANDOM_RAYS * 4 / 5) calm = 1'b1;
            send_ray(($urandom_range(0, 3) == 0) ? noise_ray() : aimed_ray());
        end
        s_valid <= 1'b0;

        waited = 0;
        while (pending_count != 0 && waited < 200000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (LATENCY + 20) @(posedge aclk);

        $display("sent %0d rays; %0d hits and %0d misses checked", sent, hit_count,
                 miss_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d failures, %0d results missing", fail_count, pending_count);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
